>>> sv/multi_mode_timer_relay_defines.svh
// Assertion macros shared by the timer relay RTL.
// Included by modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef MULTI_MODE_TIMER_RELAY_DEFINES_SVH
`define MULTI_MODE_TIMER_RELAY_DEFINES_SVH

// Check that is switched off while reset is held.
`define MMTR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that also holds during reset.
`define MMTR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/mmtr_pkg.sv
// Types and constants for the multi-mode timer relay.
// No dependencies; imported by multi_mode_timer_relay.
package mmtr_pkg;

  typedef enum logic [1:0] {
    MODE_ON_DELAY = 2'd0,
    MODE_FLICKER  = 2'd1,
    MODE_INTERVAL = 2'd2,
    MODE_DUTY     = 2'd3
  } timer_mode_e;

  localparam logic [1:0] REG_TIMER_MODE = 2'd0;
  localparam logic [1:0] REG_TIME_LIMIT = 2'd1;
  localparam logic [1:0] REG_ON_DUTY    = 2'd2;

  localparam int unsigned UNIT_W = 7;
  localparam logic [UNIT_W-1:0] UNIT_MAX        = 7'd99;
  localparam logic [UNIT_W-1:0] TIME_LIMIT_RST  = 7'd5;
  localparam logic [UNIT_W-1:0] ON_DUTY_RST     = 7'd2;

endpackage

>>> sv/multi_mode_timer_relay.sv
// Multi-mode timer relay: on-delay, flicker, interval and duty-cycle modes.
// Uses mmtr_pkg and the assertion macros in multi_mode_timer_relay_defines.svh.
//
// Channel   Direction  Content
// s_axis    in         tick, start, reset and gate sample, one per item
// m_axis    out        relay, timing flag, whole units, hundredths
// cfg       in         register write: index and 7-bit data
//
// Each result is registered on acceptance and shown in the next cycle; a new item is
// taken every cycle that the output register is empty or being drained.
// rst_ni clears the timer state, the registers to their defaults and the output valid.
// A stalled m_axis holds its item and stops s_axis; cfg is always ready.
`include "multi_mode_timer_relay_defines.svh"

module multi_mode_timer_relay
  import mmtr_pkg::*;
#(
  parameter int unsigned TICKS_PER_UNIT = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] tick, [1] start_in, [2] reset_in, [3] gate_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] relay_on, [1] timing, [8:2] whole_units,
                                      // [15:9] hundredths
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  localparam int unsigned FRAC_W = $clog2(TICKS_PER_UNIT);
  localparam logic [FRAC_W-1:0] FRAC_LAST = FRAC_W'(TICKS_PER_UNIT - 1);

  timer_mode_e         mode_q;
  logic [UNIT_W-1:0]   limit_q, duty_q;
  logic                run_q, run_d, arm_q, arm_d, rel_q, rel_d;
  logic                gp_q, gp_d, rsn_q, rsn_d;
  logic [FRAC_W-1:0]   frac_q, frac_d;
  logic [UNIT_W-1:0]   unit_q, unit_d;
  logic                out_valid_q;
  logic [15:0]         out_data_q, out_data_d;
  logic [FRAC_W+6:0]   frac_ext;
  logic                in_acc;
  logic                tick, st, rs, gt;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign tick = s_axis_tdata[0];
  assign st   = s_axis_tdata[1];
  assign rs   = s_axis_tdata[2];
  assign gt   = s_axis_tdata[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_ON_DELAY;
      limit_q <= TIME_LIMIT_RST;
      duty_q  <= ON_DUTY_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TIMER_MODE: mode_q  <= timer_mode_e'(cfg_data_i[1:0]);
        REG_TIME_LIMIT: limit_q <= cfg_data_i;
        REG_ON_DUTY:    duty_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // One step of the timer. The mode logic may end the step early (reset or
  // gate seen), in which case the tick is not applied.
  always_comb begin
    logic adv;
    adv    = 1'b0;
    run_d  = run_q;
    arm_d  = arm_q;
    rel_d  = rel_q;
    gp_d   = gp_q;
    rsn_d  = rsn_q;
    frac_d = frac_q;
    unit_d = unit_q;

    if (gp_q) begin
      if (!gt) begin
        gp_d = 1'b0;
        if (unit_q != '0 || frac_q != '0) run_d = 1'b1;
        adv = 1'b1;
      end
    end else if (rsn_q) begin
      if (rs) begin
        rel_d  = 1'b0;
        frac_d = '0;
        unit_d = '0;
        run_d  = 1'b0;
      end else begin
        rsn_d = 1'b0;
        if (mode_q == MODE_INTERVAL && st) begin
          run_d = 1'b1;
          rel_d = 1'b1;
        end
        adv = 1'b1;
      end
    end else begin
      adv = 1'b1;
      case (mode_q)
        MODE_ON_DELAY: begin
          if (unit_d >= limit_q) begin
            rel_d = 1'b1;
            run_d = 1'b0;
          end
          if (!arm_d && st && !rs) begin
            run_d = 1'b1;
            arm_d = 1'b1;
          end
        end
        MODE_FLICKER: begin
          if (!arm_d && st && !rs) begin
            run_d = 1'b1;
            arm_d = 1'b1;
          end
          if (!rs && !gt && unit_d > limit_q) begin
            rel_d  = !rel_d;
            frac_d = '0;
            unit_d = '0;
            run_d  = 1'b1;
          end
        end
        MODE_INTERVAL: begin
          if (!arm_d && st) begin
            rel_d  = 1'b1;
            frac_d = '0;
            unit_d = '0;
            run_d  = 1'b1;
            arm_d  = 1'b1;
          end
          if (!st) arm_d = 1'b0;
          if (!rs && !gt && unit_d > limit_q) begin
            frac_d = '0;
            unit_d = '0;
            run_d  = 1'b0;
            rel_d  = 1'b0;
          end
        end
        default: begin
          if (!arm_d && st && !rs) begin
            run_d = 1'b1;
            rel_d = 1'b1;
            arm_d = 1'b1;
          end
          if (unit_d > duty_q) rel_d = 1'b0;
          if (unit_d > limit_q) begin
            rel_d  = 1'b1;
            frac_d = '0;
            unit_d = '0;
            run_d  = 1'b1;
          end
        end
      endcase
      // Reset takes precedence over gate; both end the step without a tick.
      if (rs) begin
        adv    = 1'b0;
        rel_d  = 1'b0;
        frac_d = '0;
        unit_d = '0;
        run_d  = 1'b0;
        if (mode_q != MODE_INTERVAL) arm_d = 1'b0;
        rsn_d  = 1'b1;
      end else if (gt) begin
        adv   = 1'b0;
        run_d = 1'b0;
        gp_d  = 1'b1;
      end
    end

    if (adv && run_d && tick) begin
      if (frac_d == FRAC_LAST) begin
        frac_d = '0;
        if (unit_d < UNIT_MAX) unit_d = unit_d + 1'b1;
      end else begin
        frac_d = frac_d + 1'b1;
      end
    end
  end

  assign frac_ext   = {7'd0, frac_d};
  assign out_data_d = {frac_ext[6:0], unit_d, run_d, rel_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      arm_q  <= 1'b0;
      rel_q  <= 1'b0;
      gp_q   <= 1'b0;
      rsn_q  <= 1'b0;
      frac_q <= '0;
      unit_q <= '0;
    end else if (in_acc) begin
      run_q  <= run_d;
      arm_q  <= arm_d;
      rel_q  <= rel_d;
      gp_q   <= gp_d;
      rsn_q  <= rsn_d;
      frac_q <= frac_d;
      unit_q <= unit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) out_data_q <= out_data_d;
  end

  `MMTR_ASSERT(unit_in_range_a, unit_q <= UNIT_MAX, "whole units beyond saturation")
  `MMTR_ASSERT(frac_in_range_a, frac_q <= FRAC_LAST, "hundredths beyond rollover")
  `MMTR_ASSERT(gate_stops_time_a, gp_q |-> !run_q, "time runs while gate paused")
  `MMTR_ASSERT_ALWAYS(accept_gives_out_a, rst_ni && in_acc |=> !rst_ni || m_axis_tvalid,
                      "accepted item produced no result")

endmodule
